/* rtl/ardt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ardt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] MULTICAST_BIT = 8'h01;

  localparam logic [1:0] CFG_SAE_MASK  = 2'd0;
  localparam logic [1:0] CFG_PSK_MASK  = 2'd1;
  localparam logic [1:0] CFG_TKIP_MASK = 2'd2;

  localparam int FLAG_AKM  = 0;
  localparam int FLAG_MFP  = 1;
  localparam int FLAG_TKIP = 2;

  typedef enum logic [1:0] {
    MODE_OBSERVE = 2'd0,
    MODE_LOOKUP  = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_OBSERVE,
    KIND_LOOKUP,
    KIND_CLEAR,
    KIND_IGNORE
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] ap;
    logic [47:0] client;
    logic [31:0] seen_time;
    logic [31:0] akm;
    logic [31:0] pairwise;
    logic [1:0]  mfp;
  } request_t;

  typedef struct packed {
    logic     valid;
    request_t item;
  } queue_head_t;

  typedef struct packed {
    logic [47:0] ap;
    logic [47:0] client;
    logic [31:0] etime;
    logic [31:0] akm;
    logic [31:0] pairwise;
    logic [1:0]  mfp;
    logic [2:0]  flags;
    logic [31:0] old_akm;
    logic [1:0]  old_mfp;
  } entry_t;

  typedef struct packed {
    logic        accepted;
    logic        found;
    logic [5:0]  slot_index;
    logic [2:0]  downgrade_mask;
    logic [31:0] previous_akm;
    logic [1:0]  previous_mfp;
    logic [31:0] stored_akm;
    logic [31:0] stored_pairwise;
    logic [1:0]  stored_mfp;
    logic [31:0] stored_time;
    logic [6:0]  entries_used;
    logic [6:0]  downgraded_entries;
  } result_t;

  function automatic logic addr_ok(input logic [47:0] a);
    addr_ok = ((a[47:40] & MULTICAST_BIT) == 8'h00) && (a != 48'h0);
  endfunction

endpackage
`default_nettype wire

/* rtl/ardt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ardt_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          mode,
  input  wire logic [47:0]         ap_address,
  input  wire logic [47:0]         client_address,
  input  wire logic [31:0]         seen_time,
  input  wire logic [31:0]         akm_suites,
  input  wire logic [31:0]         pairwise_ciphers,
  input  wire logic [1:0]          mfp_level,
  output ardt_pkg::queue_head_t    head,
  input  wire logic                pop
);

  ardt_pkg::request_t slots [ardt_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  ardt_pkg::request_t req_in;

  always_comb begin
    req_in.ap        = ap_address;
    req_in.client    = client_address;
    req_in.seen_time = seen_time;
    req_in.akm       = akm_suites;
    req_in.pairwise  = pairwise_ciphers;
    req_in.mfp       = mfp_level;
    unique case (ardt_pkg::mode_t'(mode))
      ardt_pkg::MODE_OBSERVE: begin
        // bad addresses leave the table alone
        if (ardt_pkg::addr_ok(ap_address) && ardt_pkg::addr_ok(client_address)) begin
          req_in.kind = ardt_pkg::KIND_OBSERVE;
        end else begin
          req_in.kind = ardt_pkg::KIND_IGNORE;
        end
      end
      ardt_pkg::MODE_LOOKUP: req_in.kind = ardt_pkg::KIND_LOOKUP;
      ardt_pkg::MODE_CLEAR:  req_in.kind = ardt_pkg::KIND_CLEAR;
      default:               req_in.kind = ardt_pkg::KIND_IGNORE;
    endcase
  end

  assign in_ready   = (count != 2'(ardt_pkg::QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/ardt_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
module ardt_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  input  ardt_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ardt_pkg::result_t     res
);

  localparam int N = ardt_pkg::TABLE_ENTRIES;
  localparam int IW = ardt_pkg::IDX_W;
  localparam int CW = ardt_pkg::CNT_W;

  ardt_pkg::state_t   state, state_next;
  ardt_pkg::request_t req;
  ardt_pkg::entry_t   mem [N];
  ardt_pkg::entry_t   rd_data, hit_entry, wr_entry;

  logic [31:0] sae_mask, psk_mask, tkip_mask;
  logic [CW-1:0] used_count, flagged_count, used_next, flagged_next;
  logic [CW-1:0] issue_ptr;
  logic          rd_valid, hit, issue, start, mem_we, full, dec;
  logic [IW-1:0] rd_idx, hit_idx, min_idx, slot;
  logic [31:0]   min_time;
  logic [2:0]    min_flags, flags;
  ardt_pkg::result_t res_next;

  assign full = (used_count == CW'(N));

  always_ff @(posedge clk) begin
    if (rst) begin
      sae_mask  <= '0;
      psk_mask  <= '0;
      tkip_mask <= '0;
    end else if (cfg_we) begin
      priority case (cfg_index)
        ardt_pkg::CFG_SAE_MASK:  sae_mask  <= cfg_data;
        ardt_pkg::CFG_PSK_MASK:  psk_mask  <= cfg_data;
        ardt_pkg::CFG_TKIP_MASK: tkip_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ardt_pkg::ST_IDLE: begin
        if (head.valid && !out_valid &&
            (head.item.kind == ardt_pkg::KIND_OBSERVE ||
             head.item.kind == ardt_pkg::KIND_LOOKUP)) begin
          state_next = ardt_pkg::ST_SCAN;
        end
      end
      ardt_pkg::ST_SCAN: begin
        if (!issue && !rd_valid) state_next = ardt_pkg::ST_DECIDE;
      end
      ardt_pkg::ST_DECIDE: state_next = ardt_pkg::ST_IDLE;
      default: state_next = ardt_pkg::ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    start  = (state == ardt_pkg::ST_IDLE) && head.valid && !out_valid;
    pop    = start;
    issue  = (state == ardt_pkg::ST_SCAN) && (issue_ptr < used_count);
    mem_we = (state == ardt_pkg::ST_DECIDE) && (req.kind == ardt_pkg::KIND_OBSERVE);
  end

  // decision datapath
  always_comb begin
    flags = '0;
    if (hit) begin
      flags[ardt_pkg::FLAG_AKM] = ((hit_entry.akm & sae_mask) != 32'h0) &&
                                  ((req.akm & sae_mask) == 32'h0) &&
                                  ((req.akm & psk_mask) != 32'h0);
      flags[ardt_pkg::FLAG_MFP] = (req.mfp < hit_entry.mfp);
      flags[ardt_pkg::FLAG_TKIP] = ((hit_entry.pairwise & tkip_mask) == 32'h0) &&
                                   ((req.pairwise & tkip_mask) != 32'h0);
    end
    if (hit)       slot = hit_idx;
    else if (full) slot = min_idx;
    else           slot = used_count[IW-1:0];

    wr_entry.ap       = req.ap;
    wr_entry.client   = req.client;
    wr_entry.etime    = req.seen_time;
    wr_entry.akm      = req.akm;
    wr_entry.pairwise = req.pairwise;
    wr_entry.mfp      = req.mfp;
    wr_entry.flags    = flags;
    wr_entry.old_akm  = hit ? hit_entry.akm : 32'h0;
    wr_entry.old_mfp  = hit ? hit_entry.mfp : 2'd0;

    dec = (hit ? (hit_entry.flags != 3'd0) : (full && (min_flags != 3'd0))) &&
          (flagged_count != '0);
    used_next    = (hit || full) ? used_count : used_count + CW'(1);
    flagged_next = flagged_count - CW'(dec) + CW'(flags != 3'd0);

    res_next = '0;
    if (state == ardt_pkg::ST_DECIDE) begin
      res_next.accepted = 1'b1;
      if (req.kind == ardt_pkg::KIND_OBSERVE) begin
        res_next.found           = hit;
        res_next.slot_index      = 6'(slot);
        res_next.downgrade_mask  = flags;
        res_next.previous_akm    = wr_entry.old_akm;
        res_next.previous_mfp    = wr_entry.old_mfp;
        res_next.stored_akm      = req.akm;
        res_next.stored_pairwise = req.pairwise;
        res_next.stored_mfp      = req.mfp;
        res_next.stored_time     = req.seen_time;
        res_next.entries_used       = 7'(used_next);
        res_next.downgraded_entries = 7'(flagged_next);
      end else begin
        if (hit) begin
          res_next.found           = 1'b1;
          res_next.slot_index      = 6'(hit_idx);
          res_next.downgrade_mask  = hit_entry.flags;
          res_next.previous_akm    = hit_entry.old_akm;
          res_next.previous_mfp    = hit_entry.old_mfp;
          res_next.stored_akm      = hit_entry.akm;
          res_next.stored_pairwise = hit_entry.pairwise;
          res_next.stored_mfp      = hit_entry.mfp;
          res_next.stored_time     = hit_entry.etime;
        end
        res_next.entries_used       = 7'(used_count);
        res_next.downgraded_entries = 7'(flagged_count);
      end
    end else begin
      // clear or ignored word straight from the queue head
      res_next.accepted = (head.item.kind == ardt_pkg::KIND_CLEAR);
      if (head.item.kind != ardt_pkg::KIND_CLEAR) begin
        res_next.entries_used       = 7'(used_count);
        res_next.downgraded_entries = 7'(flagged_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[slot] <= wr_entry;
    if (issue)  rd_data <= mem[issue_ptr[IW-1:0]];
    rd_idx <= issue_ptr[IW-1:0];
    if (start) req <= head.item;
    if (rd_valid) begin
      if (!hit && rd_data.ap == req.ap && rd_data.client == req.client) begin
        hit_idx   <= rd_idx;
        hit_entry <= rd_data;
      end
      // strict compare keeps the lowest index on a tie
      if (rd_idx == '0 || rd_data.etime < min_time) begin
        min_idx   <= rd_idx;
        min_time  <= rd_data.etime;
        min_flags <= rd_data.flags;
      end
    end
    if (state == ardt_pkg::ST_DECIDE ||
        (start && !(head.item.kind == ardt_pkg::KIND_OBSERVE ||
                    head.item.kind == ardt_pkg::KIND_LOOKUP))) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ardt_pkg::ST_IDLE;
      used_count    <= '0;
      flagged_count <= '0;
      issue_ptr     <= '0;
      rd_valid      <= 1'b0;
      hit           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (start) begin
        issue_ptr <= '0;
        hit       <= 1'b0;
      end else if (issue) begin
        issue_ptr <= issue_ptr + CW'(1);
      end
      if (rd_valid && rd_data.ap == req.ap && rd_data.client == req.client) hit <= 1'b1;
      if (mem_we) begin
        used_count    <= used_next;
        flagged_count <= flagged_next;
      end
      if (start && head.item.kind == ardt_pkg::KIND_CLEAR) begin
        used_count    <= '0;
        flagged_count <= '0;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ardt_pkg::ST_DECIDE ||
          (start && !(head.item.kind == ardt_pkg::KIND_OBSERVE ||
                      head.item.kind == ardt_pkg::KIND_LOOKUP))) begin
        out_valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/assoc_request_downgrade_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// association request downgrade table
// input channel (in_valid/in_ready) carries one request word: observe,
// look up or clear. a two-word queue takes words while the table engine
// is busy, so the sender is stalled only when the queue is full.
// the engine walks the valid entries through one memory read port, one
// entry per cycle, then loads the result; an observe also writes the
// chosen slot. observe and look up pass through the scan and decide
// states after leaving the queue; clear and ignored words load their
// result straight from the queue head.
// output channel (out_valid/out_ready) holds one result word in a
// register; while it waits the engine starts nothing new, the queue
// keeps filling and then in_ready drops.
// configuration: cfg_we with cfg_index and cfg_data writes a mask register
// (0 sae family, 1 psk family, 2 tkip); write only while idle.
// reset (rst, synchronous) empties the queue and table counts and zeroes
// the masks; table contents are not cleared and need no sweep.
module assoc_request_downgrade_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [47:0] ap_address,
  input  wire logic [47:0] client_address,
  input  wire logic [31:0] seen_time,
  input  wire logic [31:0] akm_suites,
  input  wire logic [31:0] pairwise_ciphers,
  input  wire logic [1:0]  mfp_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic             found,
  output logic [5:0]       slot_index,
  output logic [2:0]       downgrade_mask,
  output logic [31:0]      previous_akm,
  output logic [1:0]       previous_mfp,
  output logic [31:0]      stored_akm,
  output logic [31:0]      stored_pairwise,
  output logic [1:0]       stored_mfp,
  output logic [31:0]      stored_time,
  output logic [6:0]       entries_used,
  output logic [6:0]       downgraded_entries
);

  ardt_pkg::queue_head_t head;
  ardt_pkg::result_t     res;
  logic                  pop;

  ardt_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .ap_address       (ap_address),
    .client_address   (client_address),
    .seen_time        (seen_time),
    .akm_suites       (akm_suites),
    .pairwise_ciphers (pairwise_ciphers),
    .mfp_level        (mfp_level),
    .head             (head),
    .pop              (pop)
  );

  ardt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign accepted           = res.accepted;
  assign found              = res.found;
  assign slot_index         = res.slot_index;
  assign downgrade_mask     = res.downgrade_mask;
  assign previous_akm       = res.previous_akm;
  assign previous_mfp       = res.previous_mfp;
  assign stored_akm         = res.stored_akm;
  assign stored_pairwise    = res.stored_pairwise;
  assign stored_mfp         = res.stored_mfp;
  assign stored_time        = res.stored_time;
  assign entries_used       = res.entries_used;
  assign downgraded_entries = res.downgraded_entries;

endmodule
`default_nettype wire

/* tb/assoc_request_downgrade_table_core_test.sv */
`timescale 1ns / 1ps
module assoc_request_downgrade_table_core_test;
  import ardt_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [47:0] ap;
    logic [47:0] cl;
    logic [31:0] t;
    logic [31:0] akm;
    logic [31:0] pw;
    logic [1:0]  mfp;
  } req_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [47:0] ap_address = '0;
  logic [47:0] client_address = '0;
  logic [31:0] seen_time = '0;
  logic [31:0] akm_suites = '0;
  logic [31:0] pairwise_ciphers = '0;
  logic [1:0] mfp_level = '0;
  logic out_valid;
  logic out_ready = 0;
  logic accepted, found;
  logic [5:0] slot_index;
  logic [2:0] downgrade_mask;
  logic [31:0] previous_akm, stored_akm, stored_pairwise, stored_time;
  logic [1:0] previous_mfp, stored_mfp;
  logic [6:0] entries_used, downgraded_entries;

  assoc_request_downgrade_table_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .ap_address(ap_address),
    .client_address(client_address), .seen_time(seen_time), .akm_suites(akm_suites),
    .pairwise_ciphers(pairwise_ciphers), .mfp_level(mfp_level), .out_valid(out_valid),
    .out_ready(out_ready), .accepted(accepted), .found(found), .slot_index(slot_index),
    .downgrade_mask(downgrade_mask), .previous_akm(previous_akm),
    .previous_mfp(previous_mfp), .stored_akm(stored_akm), .stored_pairwise(stored_pairwise),
    .stored_mfp(stored_mfp), .stored_time(stored_time), .entries_used(entries_used),
    .downgraded_entries(downgraded_entries)
  );

  always #2 clk = ~clk;

  // shadow of the table and mask registers
  entry_t shadow [TABLE_ENTRIES];
  int used_n = 0;
  int flagged_n = 0;
  logic [31:0] sae_m = '0, psk_m = '0, tkip_m = '0;

  req_t pending_words [$];
  result_t expected_results [$];
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int found_hits = 0;
  int flagged_hits = 0;

  bit took_in = 0;
  bit took_out = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int gap_max = 13;
  int long_hold = 0;

  logic [47:0] ap_pool [12];
  logic [47:0] cl_pool [8];

  function automatic bit good_addr(logic [47:0] a);
    return !a[40] && a != 48'h0;
  endfunction

  function automatic logic [47:0] raw_addr();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [1:0] rand_mfp();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic result_t predict_table(req_t r);
    result_t o;
    int hit;
    int s;
    logic [2:0] fl;
    logic [31:0] pakm;
    logic [1:0] pmfp;
    bit wasv;
    o = '0;
    hit = -1;
    fl = '0;
    pakm = '0;
    pmfp = '0;
    for (int i = 0; i < used_n; i++)
      if (hit < 0 && shadow[i].ap == r.ap && shadow[i].client == r.cl) hit = i;
    case (mode_t'(r.mode))
      MODE_OBSERVE: begin
        if (good_addr(r.ap) && good_addr(r.cl)) begin
          if (hit >= 0) begin
            s = hit;
            wasv = 1;
          end else if (used_n < TABLE_ENTRIES) begin
            s = used_n;
            used_n++;
            wasv = 0;
          end else begin
            // evict the oldest, lowest slot wins a tie
            s = 0;
            for (int i = 1; i < TABLE_ENTRIES; i++)
              if (shadow[i].etime < shadow[s].etime) s = i;
            wasv = 1;
          end
          if (hit >= 0) begin
            pakm = shadow[s].akm;
            pmfp = shadow[s].mfp;
            if ((pakm & sae_m) != 0 && (r.akm & sae_m) == 0 && (r.akm & psk_m) != 0)
              fl[FLAG_AKM] = 1'b1;
            if (r.mfp < pmfp) fl[FLAG_MFP] = 1'b1;
            if ((shadow[s].pairwise & tkip_m) == 0 && (r.pw & tkip_m) != 0)
              fl[FLAG_TKIP] = 1'b1;
          end
          if (wasv && shadow[s].flags != 0 && flagged_n > 0) flagged_n--;
          if (fl != 0) flagged_n++;
          shadow[s] = '{ap: r.ap, client: r.cl, etime: r.t, akm: r.akm, pairwise: r.pw,
                        mfp: r.mfp, flags: fl, old_akm: pakm, old_mfp: pmfp};
          o.accepted = 1;
          o.found = (hit >= 0);
          hit = s;
        end else begin
          hit = -1;
        end
      end
      MODE_LOOKUP: o.accepted = 1;
      MODE_CLEAR: begin
        used_n = 0;
        flagged_n = 0;
        o.accepted = 1;
        hit = -1;
      end
      default: hit = -1;
    endcase
    if (hit >= 0 && o.accepted) begin
      if (mode_t'(r.mode) == MODE_LOOKUP) o.found = 1;
      o.slot_index = hit[5:0];
      o.downgrade_mask = shadow[hit].flags;
      o.previous_akm = shadow[hit].old_akm;
      o.previous_mfp = shadow[hit].old_mfp;
      o.stored_akm = shadow[hit].akm;
      o.stored_pairwise = shadow[hit].pairwise;
      o.stored_mfp = shadow[hit].mfp;
      o.stored_time = shadow[hit].etime;
    end
    o.entries_used = used_n[6:0];
    o.downgraded_entries = flagged_n[6:0];
    return o;
  endfunction

  // input side: word taken at the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      req_t r;
      r = '{mode, ap_address, client_address, seen_time, akm_suites, pairwise_ciphers,
            mfp_level};
      expected_results.push_back(predict_table(r));
      words_sent++;
      took_in = 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !took_in) begin
      in_valid <= 1;
    end else begin
      took_in = 0;
      if (in_valid) send_gap = $urandom_range(0, gap_max);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 0;
      end else if (pending_words.size() > 0) begin
        req_t r;
        r = pending_words.pop_front();
        mode <= r.mode;
        ap_address <= r.ap;
        client_address <= r.cl;
        seen_time <= r.t;
        akm_suites <= r.akm;
        pairwise_ciphers <= r.pw;
        mfp_level <= r.mfp;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  task automatic check_field(string name, logic [47:0] e, logic [47:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  // output side
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      result_t e;
      took_out = 1;
      words_seen++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (found) found_hits++;
        if (downgrade_mask != 0) flagged_hits++;
        check_field("accepted", 48'(e.accepted), 48'(accepted));
        check_field("found", 48'(e.found), 48'(found));
        check_field("slot_index", 48'(e.slot_index), 48'(slot_index));
        check_field("downgrade_mask", 48'(e.downgrade_mask), 48'(downgrade_mask));
        check_field("previous_akm", 48'(e.previous_akm), 48'(previous_akm));
        check_field("previous_mfp", 48'(e.previous_mfp), 48'(previous_mfp));
        check_field("stored_akm", 48'(e.stored_akm), 48'(stored_akm));
        check_field("stored_pairwise", 48'(e.stored_pairwise), 48'(stored_pairwise));
        check_field("stored_mfp", 48'(e.stored_mfp), 48'(stored_mfp));
        check_field("stored_time", 48'(e.stored_time), 48'(stored_time));
        check_field("entries_used", 48'(e.entries_used), 48'(entries_used));
        check_field("downgraded_entries", 48'(e.downgraded_entries),
                    48'(downgraded_entries));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (long_hold > 0) begin
      long_hold--;
      out_ready <= 0;
    end else begin
      if (took_out) begin
        took_out = 0;
        recv_stall = $urandom_range(0, gap_max);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_SAE_MASK: sae_m = val;
      CFG_PSK_MASK: psk_m = val;
      default: tkip_m = val;
    endcase
  endtask

  task automatic set_masks(logic [31:0] s, logic [31:0] p, logic [31:0] t);
    write_reg(CFG_SAE_MASK, s);
    write_reg(CFG_PSK_MASK, p);
    write_reg(CFG_TKIP_MASK, t);
  endtask

  task automatic push_word(logic [1:0] m, logic [47:0] a, logic [47:0] c, logic [31:0] t,
                           logic [31:0] k, logic [31:0] p, logic [1:0] f);
    req_t r;
    r = '{m, a, c, t, k, p, f};
    pending_words.push_back(r);
  endtask

  task automatic drain;
    // checked at the rising edge, where the sender's valid has settled
    @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    // ignored words leave no trace, give the engine time to settle
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_addr();
    logic [47:0] a;
    a = raw_addr();
    a[40] = 0;
    if (a == 0) a = 48'h1;
    return a;
  endfunction

  task automatic random_words(int n);
    int pick;
    logic [47:0] a, c;
    logic [31:0] t;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      a = ap_pool[$urandom_range(0, 11)];
      c = cl_pool[$urandom_range(0, 7)];
      t = ($urandom_range(0, 1)) ? $urandom_range(0, 40) : $urandom();
      if (pick < 6) begin
        // raw addresses, multicast and zero included
        a = ($urandom_range(0, 3) == 0) ? 48'h0 : raw_addr();
        c = ($urandom_range(0, 3) == 0) ? 48'h0 : raw_addr();
        push_word(MODE_OBSERVE, a, c, t, $urandom(), $urandom(), rand_mfp());
      end else if (pick < 76) begin
        push_word(MODE_OBSERVE, a, c, t, $urandom(), $urandom(), rand_mfp());
      end else if (pick < 94) begin
        push_word(MODE_LOOKUP, a, c, t, $urandom(), $urandom(), rand_mfp());
      end else if (pick < 96) begin
        push_word(MODE_CLEAR, raw_addr(), raw_addr(),
                  $urandom(), $urandom(), $urandom(), rand_mfp());
      end else begin
        push_word(MODE_UNUSED, a, c, t, $urandom(), $urandom(), rand_mfp());
      end
    end
  endtask

  initial begin
    logic [47:0] ga, gc;
    for (int i = 0; i < 12; i++) ap_pool[i] = rand_addr();
    for (int i = 0; i < 8; i++) cl_pool[i] = rand_addr();
    ga = ap_pool[0];
    gc = cl_pool[0];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    set_masks(32'h0000_0100, 32'h0000_0002, 32'h0000_0004);
    // fresh pair, then the same pair with every downgrade at once
    push_word(MODE_OBSERVE, ga, gc, 32'd10, 32'h0000_0100, 32'h0000_0008, 2'd2);
    push_word(MODE_OBSERVE, ga, gc, 32'd11, 32'h0000_0002, 32'h0000_0004, 2'd0);
    push_word(MODE_LOOKUP, ga, gc, 32'd0, 32'd0, 32'd0, 2'd0);
    push_word(MODE_LOOKUP, ga, cl_pool[1], 32'd0, 32'd0, 32'd0, 2'd0);
    // rewrite with no downgrade clears the flag count
    push_word(MODE_OBSERVE, ga, gc, 32'd12, 32'h0000_0102, 32'h0000_0004, 2'd0);
    push_word(MODE_OBSERVE, 48'h0100_0000_0001, gc, 32'd1, 32'd1, 32'd1, 2'd1);
    push_word(MODE_OBSERVE, ga, 48'h0, 32'd1, 32'd1, 32'd1, 2'd1);
    push_word(MODE_OBSERVE, 48'hFFFF_FFFF_FFFF, gc, 32'd1, 32'd1, 32'd1, 2'd1);
    push_word(MODE_OBSERVE, 48'hFEFF_FFFF_FFFF, 48'hFEFF_FFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    push_word(MODE_OBSERVE, 48'hFEFF_FFFF_FFFF, 48'hFEFF_FFFF_FFFF, 32'h0, 32'h0,
              32'h0, 2'd1);
    push_word(MODE_LOOKUP, 48'hFEFF_FFFF_FFFF, 48'hFEFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0, 2'd0);
    push_word(MODE_LOOKUP, 48'h0, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0, 2'd0);
    push_word(MODE_UNUSED, ga, gc, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    push_word(MODE_CLEAR, ga, gc, 32'd0, 32'd0, 32'd0, 2'd0);
    push_word(MODE_LOOKUP, ga, gc, 32'd0, 32'd0, 32'd0, 2'd0);
    push_word(MODE_OBSERVE, ga, gc, 32'd5, 32'h0000_0100, 32'h0, 2'd2);
    drain();

    // fill the table with equal stamps to force lowest-slot eviction
    for (int i = 0; i < 70; i++)
      push_word(MODE_OBSERVE, ap_pool[i % 12], cl_pool[i / 12], 32'd7, $urandom(),
                $urandom(), rand_mfp());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_masks(32'h0, 32'h0, 32'h0);
        default: set_masks($urandom(), $urandom(), $urandom() & ~($urandom()));
      endcase
      gap_max = (ph == 3) ? 0 : 13;
      // receiver goes quiet while words keep coming, queue fills and stalls
      if (ph == 2) long_hold = 600;
      random_words(75);
      drain();
      random_words(75);
      drain();
    end

    $display("sent %0d words, checked %0d results, %0d hits, %0d with downgrade flags",
             words_sent, words_seen, found_hits, flagged_hits);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
rtl/ardt_pkg.sv
rtl/ardt_front.sv
rtl/ardt_engine.sv
rtl/assoc_request_downgrade_table_core.sv
tb/assoc_request_downgrade_table_core_test.sv
